[sv/fsr_pkg.sv]
package fsr_pkg;

	localparam int IDX_W     = 12;
	localparam int ELEV_IN_W = 32;
	localparam int SINK_IN_W = 13;

	// request tdata layout
	localparam int TD_NODE_LSB = 0;
	localparam int TD_RCV_LSB  = TD_NODE_LSB + IDX_W;
	localparam int TD_ELEV_LSB = TD_RCV_LSB + IDX_W;
	localparam int TD_SINK_LSB = TD_ELEV_LSB + ELEV_IN_W;
	localparam int S_TDATA_W   = 72;

	localparam int OUT_SINK_W = 12;
	localparam int M_TDATA_W  = 16;

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_QUERY = 1'b1
	} opcode_t;

endpackage

[sv/fsr_ram.sv]
module fsr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[sv/fsr_idx_reduce.sv]
module fsr_idx_reduce import fsr_pkg::*; #(
	parameter int NODE_COUNT = 4096
) (
	input  logic                          clk,
	input  logic [IDX_W-1:0]              idx,
	output logic [$clog2(NODE_COUNT)-1:0] idx_mod_s2
);

	localparam int NW = $clog2(NODE_COUNT);

	generate
		if (NODE_COUNT >= (1 << IDX_W)) begin : g_wide
			logic [IDX_W-1:0] v_s1;

			always_ff @(posedge clk) begin
				v_s1       <= idx;
				idx_mod_s2 <= NW'(v_s1);
			end
		end else begin : g_recip
			// q = floor(v * floor(2^SHIFT / N) / 2^SHIFT) is low by at most one
			localparam int SHIFT = 24;
			localparam int PW    = IDX_W + SHIFT + 1;
			localparam int QW    = 2 * IDX_W + 2;
			localparam logic [SHIFT:0] RECIP = (SHIFT + 1)'((1 << SHIFT) / NODE_COUNT);
			localparam logic [IDX_W:0] NC    = (IDX_W + 1)'(NODE_COUNT);

			logic [IDX_W-1:0] v_s1;
			logic [IDX_W-1:0] q_s1;
			logic [PW-1:0]    prod;
			logic [QW-1:0]    qn;
			logic [IDX_W:0]   diff;
			logic [IDX_W:0]   rem;

			assign prod = PW'(idx) * PW'(RECIP);
			assign qn   = QW'(q_s1) * QW'(NC);
			assign diff = {1'b0, v_s1} - qn[IDX_W:0];
			assign rem  = (diff >= NC) ? (diff - NC) : diff;

			always_ff @(posedge clk) begin
				v_s1       <= idx;
				q_s1       <= prod[IDX_W+SHIFT-1:SHIFT];
				idx_mod_s2 <= NW'(rem);
			end
		end
	endgenerate

endmodule

[sv/flow_sink_resolver.sv]
// Load request: accepted in idle, reduced, then written in dispatch; a new request is taken
// only back in idle. Query request: index reduction and setup after accept, then per push
// a fetch, node read and sink read; the deepest node and each later pop (after a stack read)
// take a fetch, node read and, unless the node is its own sink, sink read. In done the result
// goes to the output register, waiting while it is still full. Reset: asynchronous, active
// low; afterwards a pass marks every sink unresolved while no request is accepted (config writes are taken throughout).
module flow_sink_resolver import fsr_pkg::*; #(
	parameter int NODE_COUNT  = 4096,
	parameter int ELEV_BITS   = 32,
	parameter int STACK_DEPTH = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// [11:0] node_index, [23:12] receiver_index, [55:24] elevation,
	// [68:56] initial_sink, [71:69] zero
	input  logic [S_TDATA_W-1:0]  s_tdata,
	// [0] opcode
	input  logic                  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [11:0] sink_node, [15:12] zero
	output logic [M_TDATA_W-1:0]  m_tdata,
	// [0] overflow_error
	output logic                  m_tuser,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [ELEV_IN_W-1:0]  cfg_data
);

	localparam int NW  = $clog2(NODE_COUNT);
	localparam int EW  = (ELEV_BITS < ELEV_IN_W) ? ELEV_BITS : ELEV_IN_W;
	localparam int SW  = (NW + 1 > SINK_IN_W) ? NW + 1 : SINK_IN_W;
	localparam int SAW = $clog2(STACK_DEPTH);
	localparam int CW  = $clog2(STACK_DEPTH + 1);

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_REDUCE,
		S_DISPATCH,
		S_FETCH,
		S_NODE,
		S_SINK,
		S_POP,
		S_DONE
	} state_t;

	state_t               state_q;
	logic [NW-1:0]        clr_q;
	opcode_t              opcode_q;
	logic [EW-1:0]        elev_q;
	logic [SINK_IN_W-1:0] init_q;
	logic [EW-1:0]        sea_q;
	logic [NW-1:0]        top_q;
	logic [NW-1:0]        rcv_q;
	logic [CW-1:0]        cnt_q;
	logic [OUT_SINK_W-1:0] res_sink_q;
	logic                 res_err_q;
	logic                 m_tvalid_q;
	logic [OUT_SINK_W-1:0] m_sink_q;
	logic                 m_err_q;

	logic [NW-1:0]        red_node;
	logic [NW-1:0]        red_rcv;

	logic                 node_we;
	logic [NW+EW-1:0]     node_wdata;
	logic [NW+EW-1:0]     node_rdata;
	logic [NW-1:0]        node_rcv;
	logic [EW-1:0]        node_elev;

	logic                 sink_we;
	logic [NW-1:0]        sink_waddr;
	logic [SW-1:0]        sink_wdata;
	logic [SW-1:0]        sink_rdata;

	logic                 stk_we;
	logic [SAW-1:0]       stk_waddr;
	logic [NW-1:0]        stk_wdata;
	logic [SAW-1:0]       stk_raddr;
	logic [NW-1:0]        stk_rdata;

	logic                 self_sink;
	logic                 rcv_known;
	logic                 pop_now;
	logic [SW-1:0]        pop_val;
	logic                 stk_full;

	fsr_idx_reduce #(.NODE_COUNT(NODE_COUNT)) u_red_node (
		.clk        (clk),
		.idx        (s_tdata[TD_NODE_LSB +: IDX_W]),
		.idx_mod_s2 (red_node)
	);

	fsr_idx_reduce #(.NODE_COUNT(NODE_COUNT)) u_red_rcv (
		.clk        (clk),
		.idx        (s_tdata[TD_RCV_LSB +: IDX_W]),
		.idx_mod_s2 (red_rcv)
	);

	fsr_ram #(.WIDTH(NW + EW), .DEPTH(NODE_COUNT)) u_node_ram (
		.clk   (clk),
		.we    (node_we),
		.waddr (red_node),
		.wdata (node_wdata),
		.raddr (top_q),
		.rdata (node_rdata)
	);

	fsr_ram #(.WIDTH(SW), .DEPTH(NODE_COUNT)) u_sink_ram (
		.clk   (clk),
		.we    (sink_we),
		.waddr (sink_waddr),
		.wdata (sink_wdata),
		.raddr (node_rcv),
		.rdata (sink_rdata)
	);

	fsr_ram #(.WIDTH(NW), .DEPTH(STACK_DEPTH)) u_stack_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	assign node_rcv   = node_rdata[NW-1:0];
	assign node_elev  = node_rdata[NW+EW-1:NW];
	assign node_wdata = {elev_q, red_rcv};
	assign self_sink  = (node_rcv == top_q) || ($signed(node_elev) < $signed(sea_q));
	assign rcv_known  = !sink_rdata[SW-1];
	assign stk_full   = (cnt_q == CW'(STACK_DEPTH));
	// entry below the top, read in the pop cycle
	assign stk_raddr  = SAW'(cnt_q - CW'(2));

	assign pop_now = ((state_q == S_NODE) && self_sink) ||
	                 ((state_q == S_SINK) && rcv_known);
	assign pop_val = (state_q == S_NODE) ? SW'(top_q) : sink_rdata;

	always_comb begin
		node_we    = 1'b0;
		sink_we    = 1'b0;
		sink_waddr = top_q;
		sink_wdata = pop_val;
		stk_we     = 1'b0;
		stk_waddr  = SAW'(cnt_q);
		stk_wdata  = rcv_q;
		unique case (state_q)
			S_CLEAR: begin
				sink_we    = 1'b1;
				sink_waddr = clr_q;
				sink_wdata = '1;
			end
			S_DISPATCH: begin
				if (opcode_q == OP_LOAD) begin
					node_we    = 1'b1;
					sink_we    = 1'b1;
					sink_waddr = red_node;
					sink_wdata = SW'($signed(init_q));
				end else begin
					stk_we    = 1'b1;
					stk_waddr = '0;
					stk_wdata = red_node;
				end
			end
			S_NODE: begin
				sink_we = self_sink;
			end
			S_SINK: begin
				sink_we = rcv_known;
				stk_we  = !rcv_known && !stk_full;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_q      <= '0;
			sea_q      <= '0;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				sea_q <= cfg_data[EW-1:0];
			end
			if (m_tvalid_q && m_tready && (state_q != S_DONE)) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + NW'(1);
					if (clr_q == NW'(NODE_COUNT - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_tvalid) begin
						opcode_q <= opcode_t'(s_tuser);
						elev_q   <= s_tdata[TD_ELEV_LSB +: EW];
						init_q   <= s_tdata[TD_SINK_LSB +: SINK_IN_W];
						state_q  <= S_REDUCE;
					end
				end
				S_REDUCE: begin
					state_q <= S_DISPATCH;
				end
				S_DISPATCH: begin
					if (opcode_q == OP_LOAD) begin
						state_q <= S_IDLE;
					end else begin
						top_q   <= red_node;
						cnt_q   <= CW'(1);
						state_q <= S_FETCH;
					end
				end
				S_FETCH: begin
					state_q <= S_NODE;
				end
				S_NODE: begin
					rcv_q <= node_rcv;
					if (!self_sink) begin
						state_q <= S_SINK;
					end
				end
				S_SINK: begin
					if (!rcv_known) begin
						if (stk_full) begin
							res_sink_q <= '0;
							res_err_q  <= 1'b1;
							state_q    <= S_DONE;
						end else begin
							cnt_q   <= cnt_q + CW'(1);
							top_q   <= rcv_q;
							state_q <= S_FETCH;
						end
					end
				end
				S_POP: begin
					top_q   <= stk_rdata;
					state_q <= S_FETCH;
				end
				S_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_sink_q   <= res_sink_q;
						m_err_q    <= res_err_q;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (pop_now) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					res_sink_q <= pop_val[OUT_SINK_W-1:0];
					res_err_q  <= 1'b0;
					state_q    <= S_DONE;
				end else begin
					state_q <= S_POP;
				end
			end
		end
	end

	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = M_TDATA_W'(m_sink_q);
	assign m_tuser   = m_err_q;

endmodule

[tb/tb_top.sv]
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import fsr_pkg::*;

	localparam int NODES       = 4096;
	localparam int STACK_LIMIT = 4096;
	localparam int SETTLE_CYC  = 8;
	localparam int MAX_REPORTS = 10;

	typedef enum {
		WALK_ENDS,
		WALK_UNWRITTEN,
		WALK_OVERFLOWS
	} walk_kind_t;

	typedef struct packed {
		logic [IDX_W-1:0] sink;
		logic             ovf;
	} sink_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic                 s_tuser = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 m_tuser;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [ELEV_IN_W-1:0] cfg_data = '0;

	// predictor state
	logic [IDX_W-1:0]            recv_of [0:NODES-1];
	logic signed [ELEV_IN_W-1:0] elev_of [0:NODES-1];
	logic signed [SINK_IN_W-1:0] sink_of [0:NODES-1];
	logic [IDX_W-1:0]            walk_stk [0:STACK_LIMIT-1];
	bit                          node_loaded [0:NODES-1];
	logic [IDX_W-1:0]            loaded_nodes [$];
	logic signed [ELEV_IN_W-1:0] sea_lvl = '0;

	sink_result_t pending_sinks [$];
	int mismatch_count = 0;
	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	int ovf_budget = 0;

	flow_sink_resolver uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always #10 clk = ~clk;

	initial begin
		#(100_000_000);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	task automatic report_mismatch(string what, int exp_v, int got_v);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS) begin
			$display("%t: %s: expected %0d, got %0d", $realtime, what, exp_v, got_v);
		end
	endtask

	// walk from a node, writing sinks back on the way out
	function automatic sink_result_t walk_predict(logic [IDX_W-1:0] node);
		sink_result_t res;
		int depth;
		logic [IDX_W-1:0] cur;
		logic [IDX_W-1:0] nxt;
		depth = 1;
		walk_stk[0] = node;
		while (depth > 0) begin
			cur = walk_stk[depth-1];
			nxt = recv_of[cur];
			if (cur == nxt || elev_of[cur] < sea_lvl) begin
				sink_of[cur] = {1'b0, cur};
				depth--;
			end else if (!sink_of[nxt][SINK_IN_W-1]) begin
				sink_of[cur] = sink_of[nxt];
				depth--;
			end else if (depth >= STACK_LIMIT) begin
				res.sink = '0;
				res.ovf = 1'b1;
				return res;
			end else begin
				walk_stk[depth] = nxt;
				depth++;
			end
		end
		res.sink = sink_of[node][IDX_W-1:0];
		res.ovf = 1'b0;
		return res;
	endfunction

	// dry run: does a walk stay on loaded nodes, and does it overflow
	function automatic walk_kind_t check_walk(logic [IDX_W-1:0] start);
		logic [IDX_W-1:0] cur;
		int k;
		cur = start;
		for (k = 0; k < STACK_LIMIT; k++) begin
			if (!node_loaded[cur])
				return WALK_UNWRITTEN;
			if (recv_of[cur] == cur || elev_of[cur] < sea_lvl ||
					!sink_of[recv_of[cur]][SINK_IN_W-1])
				return WALK_ENDS;
			cur = recv_of[cur];
		end
		return WALK_OVERFLOWS;
	endfunction

	task automatic send_request(opcode_t op, logic [IDX_W-1:0] node, logic [IDX_W-1:0] rcv,
			logic signed [ELEV_IN_W-1:0] elev, logic signed [SINK_IN_W-1:0] isink);
		@(negedge clk);
		while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = op;
		s_tdata = {3'b000, isink, elev, rcv, node};
		do @(posedge clk); while (!s_tready);
		if (op == OP_LOAD) begin
			recv_of[node] = rcv;
			elev_of[node] = elev;
			sink_of[node] = isink;
			if (!node_loaded[node]) begin
				node_loaded[node] = 1'b1;
				loaded_nodes.push_back(node);
			end
		end else begin
			pending_sinks.push_back(walk_predict(node));
		end
	endtask

	task automatic load_node(logic [IDX_W-1:0] node, logic [IDX_W-1:0] rcv,
			logic signed [ELEV_IN_W-1:0] elev, logic signed [SINK_IN_W-1:0] isink);
		send_request(OP_LOAD, node, rcv, elev, isink);
	endtask

	task automatic query_node(logic [IDX_W-1:0] node);
		send_request(OP_QUERY, node, IDX_W'($urandom), $urandom, SINK_IN_W'($urandom));
	endtask

	task automatic settle();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending_sinks.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_sea_level(logic signed [ELEV_IN_W-1:0] lvl);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data = lvl;
		do @(posedge clk); while (!cfg_ready);
		sea_lvl = lvl;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	always @(negedge clk) begin
		m_tready = (sink_stall_pct == 0) || ($urandom_range(99) >= sink_stall_pct);
	end

	always @(posedge clk) begin
		sink_result_t exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_sinks.size() == 0) begin
				report_mismatch("unexpected result, sink", -1, int'(m_tdata[IDX_W-1:0]));
			end else begin
				exp_r = pending_sinks.pop_front();
				if (m_tdata[IDX_W-1:0] !== exp_r.sink)
					report_mismatch("sink_node", int'(exp_r.sink),
						int'(m_tdata[IDX_W-1:0]));
				if (m_tuser !== exp_r.ovf)
					report_mismatch("overflow_error", int'(exp_r.ovf), int'(m_tuser));
			end
		end
	end

	task automatic random_load();
		logic [IDX_W-1:0] node;
		logic [IDX_W-1:0] rcv;
		logic signed [ELEV_IN_W-1:0] elev;
		logic signed [SINK_IN_W-1:0] isink;
		int sz;
		int p;
		int k;
		sz = loaded_nodes.size();
		node = (sz > 0 && $urandom_range(99) < 25) ? loaded_nodes[$urandom_range(sz-1)]
			: IDX_W'($urandom_range(NODES-1));
		p = $urandom_range(99);
		if (p < 10 || sz == 0) begin
			rcv = node;
		end else if (p < 20) begin
			rcv = IDX_W'($urandom_range(NODES-1));
		end else if (p < 70) begin
			// point at a recent node so chains grow deep
			k = $urandom_range(sz < 16 ? sz-1 : 15);
			rcv = loaded_nodes[sz-1-k];
		end else begin
			rcv = loaded_nodes[$urandom_range(sz-1)];
		end
		case ($urandom_range(3))
			0: elev = sea_lvl + ELEV_IN_W'($urandom_range(64)) - ELEV_IN_W'(32);
			1: elev = $urandom & 32'h7FFF_FFFF;
			default: elev = $urandom;
		endcase
		p = $urandom_range(99);
		if (p < 65)
			isink = -13'sd1;
		else if (p < 85)
			isink = SINK_IN_W'($urandom_range(NODES-1));
		else
			isink = -SINK_IN_W'($urandom_range(4096, 2));
		load_node(node, rcv, elev, isink);
	endtask

	task automatic random_query();
		logic [IDX_W-1:0] node;
		walk_kind_t kind;
		int t;
		for (t = 0; t < 8; t++) begin
			node = loaded_nodes[$urandom_range(loaded_nodes.size()-1)];
			kind = check_walk(node);
			if (kind == WALK_ENDS || (kind == WALK_OVERFLOWS && ovf_budget > 0)) begin
				if (kind == WALK_OVERFLOWS)
					ovf_budget--;
				query_node(node);
				return;
			end
		end
		random_load();
	endtask

	task automatic test_terminal_nodes();
		load_node(12'd0, 12'd0, 32'sd0, -13'sd1);
		query_node(12'd0);
		load_node(12'd4095, 12'd0, 32'sh7FFF_FFFF, -13'sd1);
		query_node(12'd4095);
		load_node(12'd100, 12'd4095, -32'sd1, 13'sd4095);
		query_node(12'd100);
		load_node(12'd200, 12'd4095, 32'sh8000_0000, -13'sd4096);
		query_node(12'd200);
		// elevation equal to sea level is not below it
		load_node(12'd700, 12'd701, 32'sd0, -13'sd1);
		load_node(12'd701, 12'd701, 32'sd1, -13'sd1);
		query_node(12'd700);
	endtask

	task automatic test_presets_and_writeback();
		load_node(12'd300, 12'd301, 32'sd5, 13'sh0AAA);
		load_node(12'd400, 12'd300, 32'sd10, -13'sd4096);
		query_node(12'd400);
		// own preset ignored, queried node always re-examined
		load_node(12'd500, 12'd0, 32'sd7, 13'sd1234);
		query_node(12'd500);
		load_node(12'd602, 12'd602, 32'sd9, -13'sd1);
		load_node(12'd601, 12'd602, 32'sd9, -13'sd1);
		load_node(12'd600, 12'd601, 32'sd9, -13'sd1);
		query_node(12'd600);
		query_node(12'd601);
	endtask

	task automatic test_receiver_cycle();
		load_node(12'd800, 12'd801, 32'sd9, -13'sd1);
		load_node(12'd801, 12'd800, 32'sd9, -13'sd1);
		query_node(12'd800);
		load_node(12'd801, 12'd801, 32'sd9, -13'sd1);
		query_node(12'd800);
	endtask

	task automatic test_sea_extremes();
		settle();
		write_sea_level(32'sh7FFF_FFFF);
		query_node(12'd600);
		settle();
		write_sea_level(32'sh8000_0000);
		query_node(12'd100);
	endtask

	task automatic test_random_traffic(int n, int idle_pct, int stall_pct,
			logic signed [ELEV_IN_W-1:0] lvl);
		settle();
		write_sea_level(lvl);
		src_idle_pct = idle_pct;
		sink_stall_pct = stall_pct;
		ovf_budget = 2;
		repeat (n) begin
			if (loaded_nodes.size() < 2 || $urandom_range(99) < 45)
				random_load();
			else
				random_query();
		end
	endtask

	initial begin
		foreach (sink_of[i])
			sink_of[i] = '1;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		write_sea_level(32'sd0);
		test_terminal_nodes();
		test_presets_and_writeback();
		test_receiver_cycle();
		test_sea_extremes();
		test_random_traffic(335, 0, 0, $urandom);
		test_random_traffic(335, 73, 0, 32'sd0);
		test_random_traffic(335, 0, 73, -ELEV_IN_W'($urandom_range(1 << 20)));
		test_random_traffic(335, 28, 28, $urandom);
		settle();
		if (pending_sinks.size() != 0)
			report_mismatch("results still outstanding", 0, pending_sinks.size());
		if (mismatch_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
